[rtl/core/go_to_goal_p_controller_defines.svh]
// Assertion macros shared by the go-to-goal controller RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef GO_TO_GOAL_P_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_P_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GTG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GTG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/gtg_pkg.sv]
// Shared widths, types, register codes and the arctangent table of the controller.
// Depends on nothing; used by every other RTL file of the block except the assertion header.
package gtg_pkg;

   // Field and datapath widths.
   localparam int POS_W      = 20;
   localparam int HEAD_W     = 16;
   localparam int TOL_W      = 19;
   localparam int GAIN_W     = 12;
   localparam int CMD_W      = 24;
   localparam int DIFF_W     = POS_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int DIST_W     = DIFF_W;
   localparam int CX_W       = 40;
   localparam int CZ_W       = 20;
   localparam int ERR_W      = HEAD_W + 1;
   localparam int LIN_PROD_W = GAIN_W + DIST_W;
   localparam int ANG_PROD_W = GAIN_W + 1 + ERR_W;
   localparam int GAIN_FRAC  = 8;
   localparam int CORDIC_PRE = 16;

   // Pipeline depths; the rotator runs one stage longer than the root unit.
   localparam int SQRT_STAGES  = DIST_W;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_PAD   = SQRT_STAGES + 1 - CORDIC_STEPS;

   // Register port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [CZ_W-1:0] PI_Q16 = 20'sd205887;

   typedef enum logic [2:0] {
      REG_GOAL_X,
      REG_GOAL_Y,
      REG_DIST_TOL,
      REG_GAIN_LIN,
      REG_GAIN_ANG
   } reg_idx_type;

   typedef struct packed {
      logic signed [POS_W-1:0] goal_x;
      logic signed [POS_W-1:0] goal_y;
      logic [TOL_W-1:0]        arrival_tol;
      logic [GAIN_W-1:0]       gain_linear;
      logic [GAIN_W-1:0]       gain_angular;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      goal_x:       20'sd0,
      goal_y:       20'sd0,
      arrival_tol:  19'd41,
      gain_linear:  12'd256,
      gain_angular: 12'd1024
   };

   typedef struct packed {
      logic [CMD_W-1:0]        linear_cmd;
      logic signed [CMD_W-1:0] angular_cmd;
      logic                    reached;
   } rsp_payload_type;

   // Arctangent of 2^-step in Q.16 radians, rounded.
   function automatic logic signed [CZ_W-1:0] atan_q16(input int unsigned step);
      case (step)
         0:       return 20'sd51472;
         1:       return 20'sd30386;
         2:       return 20'sd16055;
         3:       return 20'sd8150;
         4:       return 20'sd4091;
         5:       return 20'sd2047;
         6:       return 20'sd1024;
         7:       return 20'sd512;
         8:       return 20'sd256;
         9:       return 20'sd128;
         10:      return 20'sd64;
         11:      return 20'sd32;
         12:      return 20'sd16;
         13:      return 20'sd8;
         14:      return 20'sd4;
         15:      return 20'sd2;
         default: return 20'sd0;
      endcase
   endfunction

endpackage

[rtl/core/gtg_ifs.sv]
// Valid/ready channel interfaces for pose samples and drive commands.
// Depends on gtg_pkg for the field widths.
interface gtg_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gtg_pkg::POS_W-1:0]    pos_x;
   logic signed [gtg_pkg::POS_W-1:0]    pos_y;
   logic signed [gtg_pkg::HEAD_W-1:0]   heading;

   modport source (output valid, pos_x, pos_y, heading, input ready);
   modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [gtg_pkg::CMD_W-1:0]           linear_cmd;
   logic signed [gtg_pkg::CMD_W-1:0]    angular_cmd;
   logic                                reached;

   modport source (output valid, linear_cmd, angular_cmd, reached, input ready);
   modport sink (input valid, linear_cmd, angular_cmd, reached, output ready);
endinterface

[rtl/core/gtg_csr.sv]
// APB-style configuration registers: goal, arrival tolerance and the two gains.
// Depends on gtg_pkg for the register codes, the config struct and its reset value.
module gtg_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gtg_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [gtg_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output gtg_pkg::cfg_type                  cfg
);
   import gtg_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        write_en;

   assign reg_idx  = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   // Write decode; addresses past the last register are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_idx)
            REG_GOAL_X:   cfg_in.goal_x       = pwdata[POS_W-1:0];
            REG_GOAL_Y:   cfg_in.goal_y       = pwdata[POS_W-1:0];
            REG_DIST_TOL: cfg_in.arrival_tol  = pwdata[TOL_W-1:0];
            REG_GAIN_LIN: cfg_in.gain_linear  = pwdata[GAIN_W-1:0];
            REG_GAIN_ANG: cfg_in.gain_angular = pwdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux, register bits zero-extended to the bus width.
   always_comb begin
      case (reg_idx)
         REG_GOAL_X:   prdata = CSR_DATA_W'(unsigned'(cfg_ff.goal_x));
         REG_GOAL_Y:   prdata = CSR_DATA_W'(unsigned'(cfg_ff.goal_y));
         REG_DIST_TOL: prdata = CSR_DATA_W'(cfg_ff.arrival_tol);
         REG_GAIN_LIN: prdata = CSR_DATA_W'(cfg_ff.gain_linear);
         REG_GAIN_ANG: prdata = CSR_DATA_W'(cfg_ff.gain_angular);
         default:      prdata = '0;
      endcase
   end

endmodule

[rtl/core/gtg_isqrt.sv]
// Pipelined integer square root, one result bit resolved per register stage.
// Depends on gtg_pkg for the radicand and root widths and the stage count.
module gtg_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [gtg_pkg::SQ_W-1:0]      radicand,
   output logic                          out_valid,
   output logic [gtg_pkg::DIST_W-1:0]    root
);
   import gtg_pkg::*;

   logic [SQ_W-1:0]        rem_ff [SQRT_STAGES];
   logic [SQ_W-1:0]        res_ff [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] valid_ff;

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [SQ_W:0] BIT = (SQ_W + 1)'(1) << (2 * (SQRT_STAGES - 1 - k));

      logic [SQ_W-1:0] rem_prev;
      logic [SQ_W-1:0] res_prev;
      logic            valid_prev;
      logic [SQ_W:0]   trial;
      logic            take;
      logic [SQ_W-1:0] rem_in;
      logic [SQ_W-1:0] res_in;

      if (k == 0) begin : g_first
         assign rem_prev   = radicand;
         assign res_prev   = '0;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign res_prev   = res_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      // Try to subtract the current partial root plus this stage's bit.
      assign trial  = {1'b0, res_prev} + BIT;
      assign take   = {1'b0, rem_prev} >= trial;
      assign rem_in = take ? rem_prev - trial[SQ_W-1:0] : rem_prev;
      assign res_in = take ? (res_prev >> 1) + BIT[SQ_W-1:0] : res_prev >> 1;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign root      = res_ff[SQRT_STAGES-1][DIST_W-1:0];

endmodule

[rtl/core/gtg_cordic.sv]
// Pipelined CORDIC vectoring unit giving the heading error (bearing minus heading).
// Depends on gtg_pkg for widths, step counts and the arctangent table.
module gtg_cordic (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [gtg_pkg::CX_W-1:0]     x0,
   input  logic signed [gtg_pkg::CX_W-1:0]     y0,
   input  logic signed [gtg_pkg::CZ_W-1:0]     z0,
   input  logic signed [gtg_pkg::HEAD_W-1:0]   heading,
   output logic signed [gtg_pkg::ERR_W-1:0]    err
);
   import gtg_pkg::*;

   logic signed [CX_W-1:0]   x_ff  [CORDIC_STEPS];
   logic signed [CX_W-1:0]   y_ff  [CORDIC_STEPS];
   logic signed [CZ_W-1:0]   z_ff  [CORDIC_STEPS];
   logic signed [HEAD_W-1:0] hd_ff [CORDIC_STEPS];
   logic signed [ERR_W-1:0]  err_ff [CORDIC_PAD];

   // One micro-rotation per stage, steering the vector toward the x axis.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [CX_W-1:0]   xp;
      logic signed [CX_W-1:0]   yp;
      logic signed [CZ_W-1:0]   zp;
      logic signed [HEAD_W-1:0] hp;
      logic signed [CX_W-1:0]   xs;
      logic signed [CX_W-1:0]   ys;
      logic signed [CX_W-1:0]   x_in;
      logic signed [CX_W-1:0]   y_in;
      logic signed [CZ_W-1:0]   z_in;

      if (i == 0) begin : g_first
         assign xp = x0;
         assign yp = y0;
         assign zp = z0;
         assign hp = heading;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign hp = hd_ff[i-1];
      end

      assign xs = xp >>> i;
      assign ys = yp >>> i;

      always_comb begin
         if (yp < 0) begin
            x_in = xp - ys;
            y_in = yp + xs;
            z_in = zp - atan_q16(i);
         end else begin
            x_in = xp + ys;
            y_in = yp - xs;
            z_in = zp + atan_q16(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]  <= x_in;
            y_ff[i]  <= y_in;
            z_ff[i]  <= z_in;
            hd_ff[i] <= hp;
         end
      end
   end

   // Round the Q.16 angle to Q.12, subtract the heading, then delay to match the root unit.
   for (genvar p = 0; p < CORDIC_PAD; p++) begin : g_pad
      logic signed [ERR_W-1:0] err_in;

      if (p == 0) begin : g_first
         logic signed [CZ_W-1:0] z_round;

         assign z_round = (z_ff[CORDIC_STEPS-1] + CZ_W'(8)) >>> 4;
         assign err_in  = ERR_W'(z_round) - ERR_W'(hd_ff[CORDIC_STEPS-1]);
      end else begin : g_next
         assign err_in = err_ff[p-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            err_ff[p] <= err_in;
         end
      end
   end

   assign err = err_ff[CORDIC_PAD-1];

endmodule

[rtl/core/go_to_goal_p_controller.sv]
// Proportional go-to-goal controller: one pose sample in, one drive command out.
// A result passes stages 1 to 3, the root unit and stage 4 into the output register.
// Every stage, root and CORDIC included, takes one item per cycle while the skid is empty.
// An output register plus one skid entry; the input is held off only while the skid is full.
// Synchronous reset clears all valid bits and loads the register defaults; no clearing pass.
`include "go_to_goal_p_controller_defines.svh"

module go_to_goal_p_controller (
   input  logic                              clock,
   input  logic                              reset,
   gtg_req_if.sink                           req_chan,
   gtg_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gtg_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [gtg_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import gtg_pkg::*;

   cfg_type cfg;

   logic en;

   // Stage 1: offsets from the pose to the goal.
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff;
   logic signed [DIFF_W-1:0] s1_dy_ff;
   logic signed [HEAD_W-1:0] s1_hd_ff;
   logic signed [DIFF_W-1:0] dx_in;
   logic signed [DIFF_W-1:0] dy_in;

   // Stage 2: squares and the CORDIC pre-rotation.
   logic                     s2_valid_ff;
   logic [SQ_W-1:0]          s2_sqx_ff;
   logic [SQ_W-1:0]          s2_sqy_ff;
   logic signed [CX_W-1:0]   s2_x0_ff;
   logic signed [CX_W-1:0]   s2_y0_ff;
   logic signed [CZ_W-1:0]   s2_z0_ff;
   logic signed [HEAD_W-1:0] s2_hd_ff;
   logic signed [SQ_W-1:0]   sqx_in;
   logic signed [SQ_W-1:0]   sqy_in;
   logic signed [CX_W-1:0]   x_shift;
   logic signed [CX_W-1:0]   y_shift;
   logic signed [CX_W-1:0]   x0_in;
   logic signed [CX_W-1:0]   y0_in;
   logic signed [CZ_W-1:0]   z0_in;

   // Stage 3: sum of squares.
   logic                     s3_valid_ff;
   logic [SQ_W-1:0]          s3_sq_ff;

   // Unit outputs.
   logic                     root_valid;
   logic [DIST_W-1:0]        goal_dist;
   logic signed [ERR_W-1:0]  err;

   // Stage 4: gain products and the arrival compare.
   logic                         s4_valid_ff;
   logic [LIN_PROD_W-1:0]        s4_lin_prod_ff;
   logic signed [ANG_PROD_W-1:0] s4_ang_prod_ff;
   logic                         s4_reached_ff;

   // Scaling, saturation and the output buffer.
   logic [LIN_PROD_W-GAIN_FRAC-1:0]        lin_shift;
   logic signed [ANG_PROD_W-GAIN_FRAC-1:0] ang_shift;
   rsp_payload_type                        pipe_out;
   rsp_payload_type                        out_ff;
   rsp_payload_type                        out_in;
   rsp_payload_type                        sk_ff;
   rsp_payload_type                        sk_in;
   logic                                   out_valid_ff;
   logic                                   out_valid_in;
   logic                                   sk_valid_ff;
   logic                                   sk_valid_in;
   logic                                   out_take;

   gtg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The whole pipeline advances while the skid entry is empty.
   assign en             = !sk_valid_ff;
   assign req_chan.ready = en;

   // Stage 1.
   assign dx_in = DIFF_W'(cfg.goal_x) - DIFF_W'(req_chan.pos_x);
   assign dy_in = DIFF_W'(cfg.goal_y) - DIFF_W'(req_chan.pos_y);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff <= dx_in;
         s1_dy_ff <= dy_in;
         s1_hd_ff <= req_chan.heading;
      end
   end

   // Stage 2: a left-half vector is turned by pi so the rotator sees x >= 0.
   assign sqx_in  = s1_dx_ff * s1_dx_ff;
   assign sqy_in  = s1_dy_ff * s1_dy_ff;
   assign x_shift = CX_W'(s1_dx_ff) <<< CORDIC_PRE;
   assign y_shift = CX_W'(s1_dy_ff) <<< CORDIC_PRE;

   always_comb begin
      if (s1_dx_ff < 0) begin
         x0_in = -x_shift;
         y0_in = -y_shift;
         z0_in = (s1_dy_ff >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
         x0_in = x_shift;
         y0_in = y_shift;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sqx_ff <= unsigned'(sqx_in);
         s2_sqy_ff <= unsigned'(sqy_in);
         s2_x0_ff  <= x0_in;
         s2_y0_ff  <= y0_in;
         s2_z0_ff  <= z0_in;
         s2_hd_ff  <= s1_hd_ff;
      end
   end

   // Stage 3.
   always_ff @(posedge clock) begin
      if (en) begin
         s3_sq_ff <= s2_sqx_ff + s2_sqy_ff;
      end
   end

   // Front-end valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   gtg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .radicand  (s3_sq_ff),
      .out_valid (root_valid),
      .root      (goal_dist)
   );

   gtg_cordic u_cordic (
      .clock   (clock),
      .en      (en),
      .x0      (s2_x0_ff),
      .y0      (s2_y0_ff),
      .z0      (s2_z0_ff),
      .heading (s2_hd_ff),
      .err     (err)
   );

   // Stage 4.
   always_ff @(posedge clock) begin
      if (en) begin
         s4_lin_prod_ff <= LIN_PROD_W'(cfg.gain_linear) * LIN_PROD_W'(goal_dist);
         s4_ang_prod_ff <= ANG_PROD_W'(signed'({1'b0, cfg.gain_angular}))
                           * ANG_PROD_W'(err);
         s4_reached_ff  <= goal_dist <= DIST_W'(cfg.arrival_tol);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= root_valid;
      end
   end

   // Drop the gain fraction and clamp. The angular product after the shift
   // always fits the command width, so it is only sign-extended.
   assign lin_shift = s4_lin_prod_ff[LIN_PROD_W-1:GAIN_FRAC];
   assign ang_shift = signed'(s4_ang_prod_ff[ANG_PROD_W-1:GAIN_FRAC]);

   always_comb begin
      pipe_out.reached = s4_reached_ff;
      if (s4_reached_ff) begin
         pipe_out.linear_cmd  = '0;
         pipe_out.angular_cmd = '0;
      end else begin
         pipe_out.linear_cmd  = (|lin_shift[LIN_PROD_W-GAIN_FRAC-1:CMD_W])
                                ? '1 : lin_shift[CMD_W-1:0];
         pipe_out.angular_cmd = CMD_W'(ang_shift);
      end
   end

   // Output register plus skid entry: a result that cannot go out parks in the skid.
   always_comb begin
      out_take     = out_valid_ff && rsp_chan.ready;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      sk_valid_in  = sk_valid_ff;
      sk_in        = sk_ff;
      if (sk_valid_ff) begin
         if (out_take) begin
            out_in      = sk_ff;
            sk_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in = s4_valid_ff;
         out_in       = pipe_out;
      end else if (s4_valid_ff) begin
         sk_valid_in = 1'b1;
         sk_in       = pipe_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sk_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sk_valid_ff  <= sk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sk_ff  <= sk_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.linear_cmd  = out_ff.linear_cmd;
   assign rsp_chan.angular_cmd = out_ff.angular_cmd;
   assign rsp_chan.reached     = out_ff.reached;

   // Checks on the output buffer and the arrival rule.
   `GTG_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, sk_valid_ff, out_valid_ff, "skid holds a result while the output register is empty")
   `GTG_ASSERT_NEXT(a_skid_drains, clock, reset, sk_valid_ff && rsp_chan.ready, !sk_valid_ff, "skid entry not drained after an output transfer")
   `GTG_ASSERT_IMPLIES(a_reached_zero, clock, reset, rsp_chan.valid && rsp_chan.reached, rsp_chan.linear_cmd == '0 && rsp_chan.angular_cmd == '0, "nonzero command with goal reached")

endmodule
